/* src/hhjc_pkg.sv */
package hhjc_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_PROBE   = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_HRD,
		S_HBK,
		S_HWR,
		S_PRD,
		S_PWR,
		S_SRD,
		S_SBK,
		S_SWR,
		S_QB0,
		S_QB1,
		S_QB2,
		S_QRD,
		S_QCMP,
		S_QOUT
	} state_t;

	localparam int KEY_W = 32;
	localparam int SHIFT_W = 5;
	localparam int MATCH_W = 13;

	typedef struct packed {
		cmd_t               command;
		logic [KEY_W-1:0]   key;
	} in_item_t;

	typedef struct packed {
		logic [MATCH_W-1:0] match_count;
		logic [31:0]        total_matches;
		logic               build_overflow;
	} out_item_t;

endpackage

/* src/histogram_hash_join_count.sv */
// A load or restart is handled without leaving the idle state; a probe on a built
// table reads its bucket's bounds, then compares each key in the bucket, and the
// next item is accepted only once the result is registered. The first probe after
// a load, restart or shift write first rebuilds the table: it clears the bounds,
// then takes a histogram of the keys, a prefix sum over the buckets and a scatter.
// Reset (arst_n low) clears control state; key and bound memories are not cleared.
module histogram_hash_join_count #(
	parameter int MAX_BUILD = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  hhjc_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output hhjc_pkg::out_item_t           out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hhjc_pkg::SHIFT_W-1:0]  cfg_data
);
	import hhjc_pkg::*;

	localparam int AW = $clog2(MAX_BUILD);
	localparam int CNT_W = $clog2(MAX_BUILD + 1);
	localparam int BIW = AW - 1;
	localparam int MW = AW - 2;

	state_t st_q, st_d;
	logic [CNT_W-1:0] n_q, idx_q, sum_q, j_q, end_q, cnt_q;
	logic built_q, ovf_q;
	logic [31:0] total_q;
	logic [SHIFT_W-1:0] sh_q;
	logic [MW-1:0] bmask_q;
	logic [BIW-1:0] bk_q;
	logic [KEY_W-1:0] key_q, skey_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [KEY_W-1:0] loaded_mem [2**AW];
	logic [KEY_W-1:0] ordered_mem [2**AW];
	logic [CNT_W-1:0] bound_mem [2**BIW];
	logic [KEY_W-1:0] loaded_rd, ordered_rd;
	logic [CNT_W-1:0] bound_rd;

	logic ld_we, ord_we, bnd_we;
	logic [AW-1:0] ld_raddr, ord_raddr, ord_waddr;
	logic [BIW-1:0] bnd_raddr, bnd_waddr;
	logic [CNT_W-1:0] bnd_wdata;

	logic in_acc;
	logic [MW-1:0] mask_new;
	logic [CNT_W-1:0] nm1;
	int k;
	logic [BIW-1:0] bkt_ld, bkt_key;
	logic [31:0] c32;
	logic [MATCH_W-1:0] c13;
	logic [32:0] tsum;
	logic [CNT_W-1:0] psum;

	function automatic logic [BIW-1:0] bucket(input logic [KEY_W-1:0] kv,
			input logic [SHIFT_W-1:0] sh, input logic [MW-1:0] m);
		logic [KEY_W-1:0] t;
		t = (kv >> sh) & KEY_W'(m);
		return t[BIW-1:0];
	endfunction

	assign in_stall = (st_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (st_q == S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_comb begin
		nm1 = n_q - CNT_W'(1);
		k = 0;
		for (int i = 0; i < CNT_W; i++) begin
			if (n_q > CNT_W'(1) && nm1[i]) begin
				k = i + 1;
			end
		end
		for (int i = 0; i < MW; i++) begin
			mask_new[i] = (i < 2) || (i + 2 < k);
		end
	end

	assign bkt_ld = bucket(loaded_rd, sh_q, bmask_q);
	assign bkt_key = bucket(key_q, sh_q, bmask_q);
	assign psum = sum_q + bound_rd;
	assign c32 = 32'(cnt_q);
	assign c13 = (c32 > 32'd8191) ? {MATCH_W{1'b1}} : c32[MATCH_W-1:0];
	assign tsum = {1'b0, total_q} + 33'(c13);

	always_comb begin
		st_d = st_q;
		ld_we = 1'b0;
		ord_we = 1'b0;
		bnd_we = 1'b0;
		ld_raddr = idx_q[AW-1:0];
		ord_raddr = j_q[AW-1:0];
		ord_waddr = bound_rd[AW-1:0];
		bnd_raddr = idx_q[BIW-1:0];
		bnd_waddr = idx_q[BIW-1:0];
		bnd_wdata = '0;
		case (st_q)
			S_IDLE: begin
				if (in_acc && in_item.command == CMD_LOAD && n_q < CNT_W'(MAX_BUILD)) begin
					ld_we = 1'b1;
				end
				if (in_acc && in_item.command == CMD_PROBE) begin
					st_d = built_q ? S_QB0 : S_CLR;
				end
			end
			S_CLR: begin
				bnd_we = 1'b1;
				if (idx_q == CNT_W'(bmask_q) + CNT_W'(2)) begin
					st_d = (n_q == '0) ? S_QB0 : S_HRD;
				end
			end
			S_HRD: st_d = S_HBK;
			S_HBK: begin
				bnd_raddr = bkt_ld + BIW'(2);
				st_d = S_HWR;
			end
			S_HWR: begin
				bnd_we = 1'b1;
				bnd_waddr = bk_q;
				bnd_wdata = bound_rd + CNT_W'(1);
				st_d = (idx_q + CNT_W'(1) == n_q) ? S_PRD : S_HRD;
			end
			S_PRD: st_d = S_PWR;
			S_PWR: begin
				bnd_we = 1'b1;
				bnd_wdata = psum;
				st_d = (idx_q == CNT_W'(bmask_q) + CNT_W'(2)) ? S_SRD : S_PRD;
			end
			S_SRD: st_d = S_SBK;
			S_SBK: begin
				bnd_raddr = bkt_ld + BIW'(1);
				st_d = S_SWR;
			end
			S_SWR: begin
				ord_we = bound_rd < CNT_W'(MAX_BUILD);
				bnd_we = 1'b1;
				bnd_waddr = bk_q;
				bnd_wdata = bound_rd + CNT_W'(1);
				st_d = (idx_q + CNT_W'(1) == n_q) ? S_QB0 : S_SRD;
			end
			S_QB0: begin
				bnd_raddr = bkt_key;
				st_d = S_QB1;
			end
			S_QB1: begin
				bnd_raddr = bk_q;
				st_d = S_QB2;
			end
			S_QB2: st_d = S_QRD;
			S_QRD: st_d = (j_q >= end_q) ? S_QOUT : S_QCMP;
			S_QCMP: st_d = S_QRD;
			S_QOUT: begin
				if (!out_valid_q || !out_stall) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			loaded_mem[n_q[AW-1:0]] <= in_item.key;
		end
		loaded_rd <= loaded_mem[ld_raddr];
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ordered_mem[ord_waddr] <= skey_q;
		end
		ordered_rd <= ordered_mem[ord_raddr];
	end

	always_ff @(posedge clk) begin
		if (bnd_we) begin
			bound_mem[bnd_waddr] <= bnd_wdata;
		end
		bound_rd <= bound_mem[bnd_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			n_q <= '0;
			built_q <= 1'b0;
			ovf_q <= 1'b0;
			total_q <= '0;
			sh_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_QOUT && st_d == S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				sh_q <= cfg_data;
				built_q <= 1'b0;
			end
			if (in_acc) begin
				case (in_item.command)
					CMD_LOAD: begin
						built_q <= 1'b0;
						if (n_q < CNT_W'(MAX_BUILD)) begin
							n_q <= n_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					CMD_RESTART: begin
						n_q <= '0;
						built_q <= 1'b0;
						ovf_q <= 1'b0;
						total_q <= '0;
					end
					default: ;
				endcase
			end
			if ((st_q == S_CLR && st_d == S_QB0) || (st_q == S_SWR && st_d == S_QB0)) begin
				built_q <= 1'b1;
			end
			if (st_q == S_QOUT && st_d == S_IDLE) begin
				total_q <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				key_q <= in_item.key;
				idx_q <= '0;
				bmask_q <= mask_new;
			end
			S_CLR: begin
				idx_q <= (idx_q == CNT_W'(bmask_q) + CNT_W'(2)) ? '0 : idx_q + CNT_W'(1);
			end
			S_HBK: bk_q <= bkt_ld + BIW'(2);
			S_HWR: begin
				if (idx_q + CNT_W'(1) == n_q) begin
					idx_q <= CNT_W'(2);
					sum_q <= '0;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_PWR: begin
				sum_q <= psum;
				idx_q <= (idx_q == CNT_W'(bmask_q) + CNT_W'(2)) ? '0 : idx_q + CNT_W'(1);
			end
			S_SBK: begin
				bk_q <= bkt_ld + BIW'(1);
				skey_q <= loaded_rd;
			end
			S_SWR: idx_q <= idx_q + CNT_W'(1);
			S_QB0: bk_q <= bkt_key + BIW'(1);
			S_QB1: j_q <= bound_rd;
			S_QB2: begin
				end_q <= bound_rd;
				cnt_q <= '0;
			end
			S_QCMP: begin
				j_q <= j_q + CNT_W'(1);
				if (ordered_rd == key_q) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			S_QOUT: begin
				if (!out_valid_q || !out_stall) begin
					out_q.match_count <= c13;
					out_q.total_matches <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
					out_q.build_overflow <= ovf_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_BUILD))
		else $error("build count above capacity");

	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_QCMP |-> j_q < end_q)
		else $error("bucket walk past its end");

	a_built_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> st_q == S_QB0)
		else $error("table marked built outside a probe");

	a_probe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_item.command == CMD_PROBE |=> in_stall)
		else $error("probe item did not occupy the block");
`endif

endmodule

/* dv/histogram_hash_join_count_test.sv */
module histogram_hash_join_count_test;
	import hhjc_pkg::*;

	localparam int BUILD_CAP = 4096;
	localparam int IDLE_LIMIT = 200000;
	localparam cmd_t CMD_NONE = cmd_t'(2'd3);

	typedef struct {
		cmd_t        command;
		logic [31:0] key;
		bit          typed;
		out_item_t   result;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SHIFT_W-1:0] cfg_data = '0;

	int unsigned key_tally[bit [31:0]];
	int unsigned loaded_total;
	logic [31:0] match_sum;
	bit dropped_seen;
	out_item_t pending_counts[$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit stall_phase = 1'b0;
	int phase_cycles = 0;
	logic [31:0] key_pool[8];

	histogram_hash_join_count dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_join();
		key_tally.delete();
		loaded_total = 0;
		match_sum = '0;
		dropped_seen = 1'b0;
	endfunction

	function automatic bit join_step(input cmd_t c, input logic [31:0] k,
			output out_item_t r);
		logic [12:0] hits;
		case (c)
			CMD_LOAD: begin
				if (loaded_total < BUILD_CAP) begin
					if (key_tally.exists(k)) key_tally[k]++;
					else key_tally[k] = 1;
					loaded_total++;
				end else begin
					dropped_seen = 1'b1;
				end
				return 1'b0;
			end
			CMD_RESTART: begin
				clear_join();
				return 1'b0;
			end
			CMD_PROBE: begin
				hits = key_tally.exists(k) ? 13'(key_tally[k]) : 13'd0;
				if (match_sum > 32'hFFFF_FFFF - hits) match_sum = 32'hFFFF_FFFF;
				else match_sum = match_sum + hits;
				r.match_count = hits;
				r.total_matches = match_sum;
				r.build_overflow = dropped_seen;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic send(input cmd_t c, input logic [31:0] k, input bit typed = 0,
			input out_item_t want = '0);
		out_item_t r;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= '{command: c, key: k};
		do @(posedge clk); while (in_stall);
		if (join_step(c, k, r)) pending_counts.push_back(typed ? want : r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_shift(input logic [SHIFT_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return $urandom();
		return key_pool[$urandom_range(0, 7)];
	endfunction

	task automatic random_block(input int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			foreach (key_pool[i]) key_pool[i] = $urandom_range(0, 3) == 0 ? $urandom()
				: $urandom_range(0, 63) << $urandom_range(0, 26);
			if ($urandom_range(0, 5) == 0) begin
				send(CMD_RESTART, $urandom());
				sent++;
			end
			n = $urandom_range(0, 40);
			sent += n;
			repeat (n) send(CMD_LOAD, pick_key());
			n = $urandom_range(1, 20);
			sent += n;
			repeat (n) begin
				case ($urandom_range(0, 19))
					0: send(CMD_NONE, $urandom());
					1: send(CMD_LOAD, pick_key());
					default: send(CMD_PROBE, pick_key());
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_counts.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				automatic out_item_t want = pending_counts.pop_front();
				if (want.match_count !== out_item.match_count) begin
					$error("match_count: expected %0d, actual %0d",
						want.match_count, out_item.match_count);
					errors++;
				end
				if (want.total_matches !== out_item.total_matches) begin
					$error("total_matches: expected %0d, actual %0d",
						want.total_matches, out_item.total_matches);
					errors++;
				end
				if (want.build_overflow !== out_item.build_overflow) begin
					$error("build_overflow: expected %0d, actual %0d",
						want.build_overflow, out_item.build_overflow);
					errors++;
				end
			end
		end
		if (phase_cycles == 0) begin
			stall_phase <= $urandom_range(0, 1);
			phase_cycles <= $urandom_range(50, 400);
		end else begin
			phase_cycles <= phase_cycles - 1;
		end
		out_stall <= stall_phase && $urandom_range(0, 2) == 0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("histogram_hash_join_count verification failed");
			$finish;
		end
	end

	initial begin
		row_t plan[$];
		logic [SHIFT_W-1:0] shifts[$];
		clear_join();
		plan = '{
			'{CMD_PROBE,   32'h0000_0000, 1, '{13'd0, 32'd0, 1'b0}},
			'{CMD_LOAD,    32'h0000_0000, 0, '0},
			'{CMD_LOAD,    32'hFFFF_FFFF, 0, '0},
			'{CMD_LOAD,    32'h0000_0000, 0, '0},
			'{CMD_PROBE,   32'h0000_0000, 1, '{13'd2, 32'd2, 1'b0}},
			'{CMD_PROBE,   32'hFFFF_FFFF, 1, '{13'd1, 32'd3, 1'b0}},
			'{CMD_PROBE,   32'h8000_0000, 1, '{13'd0, 32'd3, 1'b0}},
			'{CMD_NONE,    32'h0000_0000, 0, '0},
			'{CMD_PROBE,   32'h0000_0000, 1, '{13'd2, 32'd5, 1'b0}},
			'{CMD_LOAD,    32'h1234_5678, 0, '0},
			'{CMD_LOAD,    32'h1234_5679, 0, '0},
			'{CMD_LOAD,    32'h1234_5678, 0, '0},
			'{CMD_LOAD,    32'hFFFF_FFFF, 0, '0},
			'{CMD_LOAD,    32'h5555_AAAA, 0, '0},
			'{CMD_PROBE,   32'h1234_5678, 0, '0},
			'{CMD_PROBE,   32'hFFFF_FFFF, 0, '0},
			'{CMD_PROBE,   32'h5555_AAAA, 0, '0},
			'{CMD_PROBE,   32'hAAAA_5555, 0, '0},
			'{CMD_RESTART, 32'hFFFF_FFFF, 0, '0},
			'{CMD_PROBE,   32'h0000_0000, 1, '{13'd0, 32'd0, 1'b0}},
			'{CMD_NONE,    32'hFFFF_FFFF, 0, '0},
			'{CMD_PROBE,   32'hFFFF_FFFF, 1, '{13'd0, 32'd0, 1'b0}}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) send(plan[i].command, plan[i].key, plan[i].typed, plan[i].result);

		shifts = '{5'd31, 5'd0, 5'd7, 5'd16, 5'd3};
		shifts.push_back($urandom_range(0, 31));
		foreach (shifts[i]) begin
			write_shift(shifts[i]);
			random_block(120);
		end

		write_shift(5'd2);
		send(CMD_RESTART, 32'd0);
		for (int i = 0; i < 60; i++)
			send(CMD_LOAD, i % 3 == 0 ? 32'hFFFF_FFFF : (i % 5 == 0 ? 32'd0 : $urandom()));
		repeat (6) send(CMD_PROBE, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0);
		send(CMD_PROBE, $urandom());

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("histogram_hash_join_count verification clean");
		else
			$display("histogram_hash_join_count verification failed");
		$finish;
	end

endmodule

/* sim.f */
src/hhjc_pkg.sv
src/histogram_hash_join_count.sv
dv/histogram_hash_join_count_test.sv
